[rtl/fmdr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmdr_pkg
// Shared types and constants of the fog mask disk reveal block: grid
// geometry, item layouts, register map and item mode codes.
// ----------------------------------------------------------------------------
package fmdr_pkg;

   // Grid geometry. Pixel fields are 8 bits wide, so the grid is at most 256.
   localparam int GRID_SIZE = 256;
   localparam int GRID_BITS = $clog2(GRID_SIZE);
   localparam int ADDR_BITS = 2 * GRID_BITS;
   localparam int CELLS     = GRID_SIZE * GRID_SIZE;

   // Radius and derived arithmetic widths.
   localparam int RADIUS_BITS = 9;
   localparam int DIFF_BITS   = RADIUS_BITS + 1;  // signed cell offset within the box
   localparam int SQR_BITS    = 2 * (RADIUS_BITS - 1) + 1;  // holds 256 squared
   localparam int CELL_BITS   = 33;               // signed mapped cell coordinate
   localparam int BOX_BITS    = CELL_BITS + 2;    // room for centre plus or minus radius

   // Colour shown for revealed cells and whenever fog is disabled.
   localparam logic [23:0] VISIBLE_RGB = 24'h334433;

   // Register reset values.
   localparam logic [30:0] HALF_EXTENT_RESET = 31'd65536;
   localparam logic [31:0] TEXEL_SCALE_RESET = 32'd65536;
   localparam logic [RADIUS_BITS-1:0] REVEAL_RADIUS_RESET = 9'd1;

   // Register map, word index taken from the byte address.
   localparam int CSR_ADDR_BITS = 5;
   typedef enum logic [2:0] {
      REG_FOG_ENABLED       = 3'd0,
      REG_BACKGROUND_COLOUR = 3'd1,
      REG_HALF_EXTENT       = 3'd2,
      REG_TEXEL_SCALE       = 3'd3,
      REG_REVEAL_RADIUS     = 3'd4
   } reg_index_type;

   // Item modes.
   localparam logic [1:0] MODE_MOVE  = 2'd0;
   localparam logic [1:0] MODE_CLEAR = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;

   // Input item.
   typedef struct packed {
      logic [1:0]          mode;
      logic signed [31:0]  world_x;
      logic signed [31:0]  world_z;
      logic [7:0]          pixel_x;
      logic [7:0]          pixel_y;
   } req_type;

   // Result item.
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       cell_revealed;
   } rsp_type;

endpackage

[rtl/fmdr_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmdr_ram
// Generic simple dual-port RAM: one write port and one read port with
// registered read data.
// ----------------------------------------------------------------------------
module fmdr_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/fmdr_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmdr_mul
// Shared 32 by 32 bit unsigned multiplier with a registered product. It maps
// world positions to cells and squares the radius and the cell offsets.
// ----------------------------------------------------------------------------
module fmdr_mul (
   input  logic        clock,
   input  logic [31:0] op_a,
   input  logic [31:0] op_b,
   output logic [63:0] product
);

   logic [63:0] product_ff;
   logic [63:0] product_in;

   // One multiplication per cycle, result available on the next cycle.
   assign product_in = 64'(op_a) * 64'(op_b);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

[rtl/fog_mask_disk_reveal.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fog_mask_disk_reveal
// Fog of war mask on a 256 by 256 cell grid. Move items map a world position
// to a cell and reveal a filled disk around it, clear items hide every cell,
// and read items return the colour and mask bit of one cell.
// ----------------------------------------------------------------------------
// Order of work: a read item passes the two read states, a move item with fog
// off goes straight to the result, and a move item maps both coordinates,
// squares the radius and then visits each in-grid cell of the square of side
// 2r+1 through the one shared multiplier; a clear item hides every cell.
// One item at a time: req_ready is high only while the block is idle.
// Reset sets control state and registers to their reset values, then a
// clearing pass hides every cell, one mask write per cycle, with req_ready low.
// ----------------------------------------------------------------------------
module fog_mask_disk_reveal (
   input  logic                                 clock,
   input  logic                                 reset,
   // Input items
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  fmdr_pkg::req_type                    req_data,
   // Result items
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output fmdr_pkg::rsp_type                    rsp_data,
   // Register port
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [fmdr_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [31:0]                          csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready
);

   // Sequencer states.
   typedef enum logic [14:0] {
      S_IDLE  = 15'b000000000000001,
      S_CLEAR = 15'b000000000000010,
      S_SUMX  = 15'b000000000000100,
      S_MULX  = 15'b000000000001000,
      S_SUMZ  = 15'b000000000010000,
      S_MULZ  = 15'b000000000100000,
      S_SQR   = 15'b000000001000000,
      S_BOX   = 15'b000000010000000,
      S_DY    = 15'b000000100000000,
      S_DY2   = 15'b000001000000000,
      S_DX    = 15'b000010000000000,
      S_WR    = 15'b000100000000000,
      S_READ  = 15'b001000000000000,
      S_READ2 = 15'b010000000000000,
      S_RESP  = 15'b100000000000000
   } state_type;

   // Configuration registers.
   logic                                 fog_enabled_ff,       fog_enabled_in;
   logic [23:0]                          background_colour_ff, background_colour_in;
   logic [30:0]                          half_extent_ff,       half_extent_in;
   logic [31:0]                          texel_scale_ff,       texel_scale_in;
   logic [fmdr_pkg::RADIUS_BITS-1:0]     reveal_radius_ff,     reveal_radius_in;

   // Sequencer registers.
   state_type                            state_ff,     state_in;
   logic [fmdr_pkg::ADDR_BITS-1:0]       clr_ff,       clr_in;
   logic                                 from_item_ff, from_item_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   fmdr_pkg::rsp_type                    rsp_data_ff,  rsp_data_in;
   fmdr_pkg::req_type                    item_ff,      item_in;
   fmdr_pkg::rsp_type                    res_ff,       res_in;
   logic [31:0]                          mag_ff,       mag_in;
   logic                                 neg_ff,       neg_in;
   logic signed [fmdr_pkg::CELL_BITS-1:0] cx_ff,       cx_in;
   logic signed [fmdr_pkg::CELL_BITS-1:0] cy_ff,       cy_in;
   logic [fmdr_pkg::SQR_BITS-1:0]        r2_ff,        r2_in;
   logic [fmdr_pkg::SQR_BITS-1:0]        dy2_ff,       dy2_in;
   logic [fmdr_pkg::GRID_BITS-1:0]       x_ff,         x_in;
   logic [fmdr_pkg::GRID_BITS-1:0]       y_ff,         y_in;
   logic [fmdr_pkg::GRID_BITS-1:0]       x0_ff,        x0_in;
   logic [fmdr_pkg::GRID_BITS-1:0]       x1_ff,        x1_in;
   logic [fmdr_pkg::GRID_BITS-1:0]       y1_ff,        y1_in;

   // Shared multiplier and mask memory.
   logic [31:0]                          mul_a;
   logic [31:0]                          mul_b;
   logic [63:0]                          mul_p;
   logic                                 ram_we;
   logic [fmdr_pkg::ADDR_BITS-1:0]       ram_waddr;
   logic                                 ram_wdata;
   logic [fmdr_pkg::ADDR_BITS-1:0]       ram_raddr;
   logic                                 ram_rdata;

   // Datapath signals.
   logic                                 csr_write;
   logic signed [31:0]                   world;
   logic signed [33:0]                   sum;
   logic signed [33:0]                   sum_neg;
   logic signed [fmdr_pkg::CELL_BITS-1:0] cell_pos;
   logic signed [fmdr_pkg::CELL_BITS-1:0] cell_signed;
   logic signed [fmdr_pkg::BOX_BITS-1:0] radius_box;
   logic signed [fmdr_pkg::BOX_BITS-1:0] last_box;
   logic signed [fmdr_pkg::BOX_BITS-1:0] bx_lo, bx_hi, by_lo, by_hi;
   logic signed [fmdr_pkg::BOX_BITS-1:0] bx0, bx1, by0, by1;
   logic                                 box_empty;
   logic [fmdr_pkg::DIFF_BITS-1:0]       dx, dy;
   logic [fmdr_pkg::DIFF_BITS-1:0]       dx_abs, dy_abs;
   logic [fmdr_pkg::SQR_BITS:0]          dist2;
   logic                                 in_disk;
   logic                                 in_grid;
   logic                                 bit_read;
   logic [23:0]                          colour;

   // ---------------------------------------------------------------------
   // Register port
   // ---------------------------------------------------------------------

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   // Register writes.
   always_comb begin
      fog_enabled_in       = fog_enabled_ff;
      background_colour_in = background_colour_ff;
      half_extent_in       = half_extent_ff;
      texel_scale_in       = texel_scale_ff;
      reveal_radius_in     = reveal_radius_ff;
      if (csr_write) begin
         unique case (csr_paddr[4:2])
            fmdr_pkg::REG_FOG_ENABLED:       fog_enabled_in       = csr_pwdata[0];
            fmdr_pkg::REG_BACKGROUND_COLOUR: background_colour_in = csr_pwdata[23:0];
            fmdr_pkg::REG_HALF_EXTENT:       half_extent_in       = csr_pwdata[30:0];
            fmdr_pkg::REG_TEXEL_SCALE:       texel_scale_in       = csr_pwdata;
            fmdr_pkg::REG_REVEAL_RADIUS:
               reveal_radius_in = csr_pwdata[fmdr_pkg::RADIUS_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Register reads.
   always_comb begin
      unique case (csr_paddr[4:2])
         fmdr_pkg::REG_FOG_ENABLED:       csr_prdata = 32'(fog_enabled_ff);
         fmdr_pkg::REG_BACKGROUND_COLOUR: csr_prdata = 32'(background_colour_ff);
         fmdr_pkg::REG_HALF_EXTENT:       csr_prdata = 32'(half_extent_ff);
         fmdr_pkg::REG_TEXEL_SCALE:       csr_prdata = texel_scale_ff;
         fmdr_pkg::REG_REVEAL_RADIUS:     csr_prdata = 32'(reveal_radius_ff);
         default:                         csr_prdata = 32'd0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Shared units
   // ---------------------------------------------------------------------

   fmdr_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_p)
   );

   fmdr_ram #(
      .WIDTH (1),
      .DEPTH (fmdr_pkg::CELLS)
   ) u_mask (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // ---------------------------------------------------------------------
   // Datapath
   // ---------------------------------------------------------------------

   // World coordinate plus half extent, split into sign and magnitude.
   assign world   = (state_ff == S_SUMZ) ? item_ff.world_z : item_ff.world_x;
   assign sum     = {{2{world[31]}}, world} + {3'b000, half_extent_ff};
   assign sum_neg = -sum;

   // Integer part of the product, with the sign restored.
   assign cell_pos    = {1'b0, mul_p[63:32]};
   assign cell_signed = neg_ff ? -cell_pos : cell_pos;

   // Bounding square of the disk, clipped to the grid.
   assign radius_box = {{(fmdr_pkg::BOX_BITS-fmdr_pkg::RADIUS_BITS){1'b0}}, reveal_radius_ff};
   assign last_box   = fmdr_pkg::BOX_BITS'(fmdr_pkg::GRID_SIZE - 1);
   assign bx_lo = {{2{cx_ff[fmdr_pkg::CELL_BITS-1]}}, cx_ff} - radius_box;
   assign bx_hi = {{2{cx_ff[fmdr_pkg::CELL_BITS-1]}}, cx_ff} + radius_box;
   assign by_lo = {{2{cy_ff[fmdr_pkg::CELL_BITS-1]}}, cy_ff} - radius_box;
   assign by_hi = {{2{cy_ff[fmdr_pkg::CELL_BITS-1]}}, cy_ff} + radius_box;
   assign bx0   = bx_lo[fmdr_pkg::BOX_BITS-1] ? '0 : bx_lo;
   assign bx1   = (bx_hi > last_box) ? last_box : bx_hi;
   assign by0   = by_lo[fmdr_pkg::BOX_BITS-1] ? '0 : by_lo;
   assign by1   = (by_hi > last_box) ? last_box : by_hi;
   assign box_empty = (bx0 > bx1) || (by0 > by1);

   // Offsets from the centre. Inside the clipped square they never exceed the
   // radius, so the low bits of the difference are exact.
   assign dx     = fmdr_pkg::DIFF_BITS'(x_ff) - cx_ff[fmdr_pkg::DIFF_BITS-1:0];
   assign dy     = fmdr_pkg::DIFF_BITS'(y_ff) - cy_ff[fmdr_pkg::DIFF_BITS-1:0];
   assign dx_abs = dx[fmdr_pkg::DIFF_BITS-1] ? -dx : dx;
   assign dy_abs = dy[fmdr_pkg::DIFF_BITS-1] ? -dy : dy;

   // Squared distance against squared radius.
   assign dist2   = {1'b0, mul_p[fmdr_pkg::SQR_BITS-1:0]} + {1'b0, dy2_ff};
   assign in_disk = dist2 <= {1'b0, r2_ff};

   // Read item colour.
   assign in_grid  = (32'(item_ff.pixel_x) < fmdr_pkg::GRID_SIZE) &&
                     (32'(item_ff.pixel_y) < fmdr_pkg::GRID_SIZE);
   assign bit_read = in_grid && ram_rdata;
   assign colour   = (fog_enabled_ff && !bit_read) ? background_colour_ff
                                                   : fmdr_pkg::VISIBLE_RGB;

   // Mask memory ports.
   assign ram_raddr = {item_ff.pixel_y[fmdr_pkg::GRID_BITS-1:0],
                       item_ff.pixel_x[fmdr_pkg::GRID_BITS-1:0]};
   assign ram_we    = (state_ff == S_CLEAR) || ((state_ff == S_WR) && in_disk);
   assign ram_waddr = (state_ff == S_CLEAR) ? clr_ff : {y_ff, x_ff};
   assign ram_wdata = (state_ff == S_WR);

   // Multiplier operands.
   always_comb begin
      mul_a = 32'd0;
      mul_b = 32'd0;
      unique case (state_ff) inside
         S_MULX, S_MULZ: begin
            mul_a = mag_ff;
            mul_b = texel_scale_ff;
         end
         S_SQR: begin
            mul_a = 32'(reveal_radius_ff);
            mul_b = 32'(reveal_radius_ff);
         end
         S_DY: begin
            mul_a = 32'(dy_abs);
            mul_b = 32'(dy_abs);
         end
         S_DX: begin
            mul_a = 32'(dx_abs);
            mul_b = 32'(dx_abs);
         end
         default: ;
      endcase
   end

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      from_item_in = from_item_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      item_in      = item_ff;
      res_in       = res_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      r2_in        = r2_ff;
      dy2_in       = dy2_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      x0_in        = x0_ff;
      x1_in        = x1_ff;
      y1_in        = y1_ff;

      unique case (state_ff)
         // Take an item and dispatch on its mode.
         S_IDLE: begin
            if (req_valid) begin
               item_in = req_data;
               res_in  = '0;
               if (req_data.mode == fmdr_pkg::MODE_MOVE && fog_enabled_ff) begin
                  state_in = S_SUMX;
               end else if (req_data.mode == fmdr_pkg::MODE_CLEAR) begin
                  clr_in       = '0;
                  from_item_in = 1'b1;
                  state_in     = S_CLEAR;
               end else if (req_data.mode == fmdr_pkg::MODE_READ) begin
                  state_in = S_READ;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         // Hide one cell per cycle.
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = from_item_ff ? S_RESP : S_IDLE;
            end
         end
         S_SUMX: begin
            mag_in   = sum[33] ? sum_neg[31:0] : sum[31:0];
            neg_in   = sum[33];
            state_in = S_MULX;
         end
         S_MULX: begin
            state_in = S_SUMZ;
         end
         S_SUMZ: begin
            cx_in    = cell_signed;
            mag_in   = sum[33] ? sum_neg[31:0] : sum[31:0];
            neg_in   = sum[33];
            state_in = S_MULZ;
         end
         S_MULZ: begin
            state_in = S_SQR;
         end
         S_SQR: begin
            cy_in    = cell_signed;
            state_in = S_BOX;
         end
         // Latch the squared radius and the clipped square.
         S_BOX: begin
            r2_in = mul_p[fmdr_pkg::SQR_BITS-1:0];
            x0_in = bx0[fmdr_pkg::GRID_BITS-1:0];
            x1_in = bx1[fmdr_pkg::GRID_BITS-1:0];
            y1_in = by1[fmdr_pkg::GRID_BITS-1:0];
            x_in  = bx0[fmdr_pkg::GRID_BITS-1:0];
            y_in  = by0[fmdr_pkg::GRID_BITS-1:0];
            state_in = box_empty ? S_RESP : S_DY;
         end
         S_DY: begin
            state_in = S_DY2;
         end
         S_DY2: begin
            dy2_in   = mul_p[fmdr_pkg::SQR_BITS-1:0];
            state_in = S_DX;
         end
         S_DX: begin
            state_in = S_WR;
         end
         // Cell written by the memory port; step along the row.
         S_WR: begin
            if (x_ff == x1_ff) begin
               x_in = x0_ff;
               if (y_ff == y1_ff) begin
                  state_in = S_RESP;
               end else begin
                  y_in     = y_ff + 1'b1;
                  state_in = S_DY;
               end
            end else begin
               x_in     = x_ff + 1'b1;
               state_in = S_DX;
            end
         end
         S_READ: begin
            state_in = S_READ2;
         end
         S_READ2: begin
            res_in.red           = colour[23:16];
            res_in.green         = colour[15:8];
            res_in.blue          = colour[7:0];
            res_in.cell_revealed = bit_read;
            state_in             = S_RESP;
         end
         // Load the output register once it is free.
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff             <= S_CLEAR;
         clr_ff               <= '0;
         from_item_ff         <= 1'b0;
         rsp_valid_ff         <= 1'b0;
         fog_enabled_ff       <= 1'b0;
         background_colour_ff <= 24'd0;
         half_extent_ff       <= fmdr_pkg::HALF_EXTENT_RESET;
         texel_scale_ff       <= fmdr_pkg::TEXEL_SCALE_RESET;
         reveal_radius_ff     <= fmdr_pkg::REVEAL_RADIUS_RESET;
      end else begin
         state_ff             <= state_in;
         clr_ff               <= clr_in;
         from_item_ff         <= from_item_in;
         rsp_valid_ff         <= rsp_valid_in;
         fog_enabled_ff       <= fog_enabled_in;
         background_colour_ff <= background_colour_in;
         half_extent_ff       <= half_extent_in;
         texel_scale_ff       <= texel_scale_in;
         reveal_radius_ff     <= reveal_radius_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      item_ff     <= item_in;
      res_ff      <= res_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      r2_ff       <= r2_in;
      dy2_ff      <= dy2_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      x0_ff       <= x0_in;
      x1_ff       <= x1_in;
      y1_ff       <= y1_in;
   end

endmodule

[tb/tb_fog_mask_disk_reveal.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fog_mask_disk_reveal
// Self-checking bench for the fog mask disk reveal block. A directed table
// covers reset state, the field extremes and each mode. It is followed by
// random segments under several register settings. Every result item is
// checked against a typed-in answer or a local model of mask and colour rule.
// ----------------------------------------------------------------------------
module tb_fog_mask_disk_reveal;
   import fmdr_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int QUIET_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 20;
   localparam int MAX_REPORTS  = 10;

   localparam rsp_type BLANK_PIXEL    = '0;
   localparam rsp_type VISIBLE_HIDDEN = {VISIBLE_RGB, 1'b0};
   localparam rsp_type VISIBLE_SHOWN  = {VISIBLE_RGB, 1'b1};
   localparam rsp_type WHITE_HIDDEN   = {24'hFFFFFF, 1'b0};

   // One row of the directed table: a register write or an item.
   typedef struct {
      bit            is_reg;
      reg_index_type reg_idx;
      logic [31:0]   reg_value;
      req_type       item;
      bit            fixed;
      rsp_type       answer;
   } step_type;

   // Expectation typed in by hand for a directed item, if any.
   typedef struct {
      bit      fixed;
      rsp_type answer;
   } fixed_answer_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   req_type                  req_data;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   rsp_type                  rsp_data;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [31:0]              csr_pwdata;
   logic [31:0]              csr_prdata;
   logic                     csr_pready;

   // Model of the block: mask bits and register copies.
   bit                   mask_model [0:CELLS-1];
   bit                   cfg_fog    = 1'b0;
   logic [23:0]          cfg_bg     = '0;
   logic [30:0]          cfg_half   = HALF_EXTENT_RESET;
   logic [31:0]          cfg_scale  = TEXEL_SCALE_RESET;
   logic [RADIUS_BITS-1:0] cfg_radius = REVEAL_RADIUS_RESET;

   rsp_type          expected_pixels [$];
   fixed_answer_type fixed_answers [$];
   step_type         steps [$];

   int items_sent    = 0;
   int results_seen  = 0;
   int error_count   = 0;
   int quiet_cycles  = 0;
   int send_idle_pct = 9;
   int recv_idle_pct = 54;

   fog_mask_disk_reveal u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic note_error(string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) begin
         $display("[%0t] %s", $time, msg);
      end
   endtask

   function automatic logic [31:0] register_mask(reg_index_type idx);
      case (idx)
         REG_FOG_ENABLED:       return 32'h0000_0001;
         REG_BACKGROUND_COLOUR: return 32'h00FF_FFFF;
         REG_HALF_EXTENT:       return 32'h7FFF_FFFF;
         REG_TEXEL_SCALE:       return 32'hFFFF_FFFF;
         REG_REVEAL_RADIUS:     return 32'h0000_01FF;
         default:               return 32'h0;
      endcase
   endfunction

   // World coordinate to cell: add the half extent, scale, truncate toward zero.
   function automatic longint map_to_cell(logic [31:0] raw, logic [30:0] half,
                                          logic [31:0] scale);
      longint          sum;
      longint unsigned mag;
      longint unsigned whole;
      sum = longint'($signed(raw)) + longint'(half);
      mag = (sum < 0) ? -sum : sum;
      whole = (mag * longint'(scale)) >> 32;
      return (sum < 0) ? -longint'(whole) : longint'(whole);
   endfunction

   // Set every in-grid cell of the disk around the center.
   function automatic void reveal_disk(longint cx, longint cy);
      longint r;
      longint x0, x1, y0, y1;
      r  = longint'(cfg_radius);
      x0 = (cx - r < 0) ? 0 : cx - r;
      y0 = (cy - r < 0) ? 0 : cy - r;
      x1 = (cx + r > GRID_SIZE - 1) ? GRID_SIZE - 1 : cx + r;
      y1 = (cy + r > GRID_SIZE - 1) ? GRID_SIZE - 1 : cy + r;
      for (longint y = y0; y <= y1; y++) begin
         for (longint x = x0; x <= x1; x++) begin
            if ((x - cx) * (x - cx) + (y - cy) * (y - cy) <= r * r) begin
               mask_model[int'(y) * GRID_SIZE + int'(x)] = 1'b1;
            end
         end
      end
   endfunction

   // Apply one item to the model and return its result item.
   function automatic rsp_type apply_item(req_type it);
      rsp_type     pix;
      bit          seen;
      logic [23:0] colour;
      pix = BLANK_PIXEL;
      case (it.mode)
         MODE_MOVE: begin
            if (cfg_fog) begin
               reveal_disk(map_to_cell(it.world_x, cfg_half, cfg_scale),
                           map_to_cell(it.world_z, cfg_half, cfg_scale));
            end
         end
         MODE_CLEAR: begin
            foreach (mask_model[i]) mask_model[i] = 1'b0;
         end
         MODE_READ: begin
            seen = mask_model[int'(it.pixel_y) * GRID_SIZE + int'(it.pixel_x)];
            colour = (cfg_fog && !seen) ? cfg_bg : VISIBLE_RGB;
            pix = {colour, seen};
         end
         default: begin
         end
      endcase
      return pix;
   endfunction

   task automatic check_pixel(rsp_type got, rsp_type want);
      if (got.red !== want.red)
         note_error($sformatf("red mismatch: expected %0h actual %0h", want.red, got.red));
      if (got.green !== want.green)
         note_error($sformatf("green mismatch: expected %0h actual %0h",
                              want.green, got.green));
      if (got.blue !== want.blue)
         note_error($sformatf("blue mismatch: expected %0h actual %0h", want.blue, got.blue));
      if (got.cell_revealed !== want.cell_revealed)
         note_error($sformatf("cell_revealed mismatch: expected %0b actual %0b",
                              want.cell_revealed, got.cell_revealed));
   endtask

   // Result side stalls at random at the rate of the current phase.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Monitor: predicts accepted items, checks result items, tracks registers.
   always @(posedge clock) begin
      rsp_type          want;
      fixed_answer_type tag;
      bit               busy;
      if (!reset) begin
         busy = 1'b0;
         if (rsp_valid && rsp_ready) begin
            busy = 1'b1;
            results_seen++;
            if (expected_pixels.size() == 0) begin
               note_error("result item arrived with nothing expected");
            end else begin
               check_pixel(rsp_data, expected_pixels.pop_front());
            end
         end
         if (req_valid && req_ready) begin
            busy = 1'b1;
            want = apply_item(req_data);
            tag = fixed_answers.pop_front();
            if (tag.fixed) want = tag.answer;
            expected_pixels.insert(expected_pixels.size(), want);
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            busy = 1'b1;
            case (reg_index_type'(csr_paddr[CSR_ADDR_BITS-1:2]))
               REG_FOG_ENABLED:       cfg_fog    = csr_pwdata[0];
               REG_BACKGROUND_COLOUR: cfg_bg     = csr_pwdata[23:0];
               REG_HALF_EXTENT:       cfg_half   = csr_pwdata[30:0];
               REG_TEXEL_SCALE:       cfg_scale  = csr_pwdata;
               REG_REVEAL_RADIUS:     cfg_radius = csr_pwdata[RADIUS_BITS-1:0];
               default: begin
               end
            endcase
         end
         quiet_cycles = busy ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[%0t] no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // Offer one item, with a random gap first, and return after it is taken.
   task automatic send_item(req_type it, bit fixed, rsp_type answer);
      fixed_answer_type tag;
      int               gap;
      tag.fixed  = fixed;
      tag.answer = answer;
      fixed_answers.insert(fixed_answers.size(), tag);
      items_sent++;
      gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(4, 1) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (!req_ready);
   endtask

   // Let every outstanding item finish so that registers may change.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (results_seen < items_sent) @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Register write followed by a read back of the same register.
   task automatic write_register(reg_index_type idx, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== (value & register_mask(idx))) begin
         note_error($sformatf("register %s read back: expected %0h actual %0h", idx.name(),
                              value & register_mask(idx), csr_prdata));
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(bit fog, logic [23:0] bg, logic [30:0] half, logic [31:0] scale,
                             logic [8:0] radius);
      wait_idle();
      write_register(REG_FOG_ENABLED, {31'd0, fog});
      write_register(REG_BACKGROUND_COLOUR, {8'd0, bg});
      write_register(REG_HALF_EXTENT, {1'b0, half});
      write_register(REG_TEXEL_SCALE, scale);
      write_register(REG_REVEAL_RADIUS, {23'd0, radius});
   endtask

   // Registers for a world of random extent mapped onto the grid; returns
   // the world range that lands on the grid and a little around it.
   task automatic set_extent_config(bit fog, logic [8:0] radius, output longint lo,
                                    output int unsigned span);
      int unsigned extent;
      extent = $urandom_range(512, 1);
      set_config(fog, 24'($urandom), 31'(extent << 16), (255 << 16) / (2 * extent), radius);
      lo   = -longint'((extent << 16) + (extent << 12));
      span = 2 * ((extent << 16) + (extent << 12));
   endtask

   function automatic req_type item_of(logic [1:0] mode, logic [31:0] wx, logic [31:0] wz,
                                       logic [7:0] px, logic [7:0] py);
      req_type it;
      it.mode    = mode;
      it.world_x = wx;
      it.world_z = wz;
      it.pixel_x = px;
      it.pixel_y = py;
      return it;
   endfunction

   function automatic step_type reg_step(reg_index_type idx, logic [31:0] value);
      step_type s;
      s = '{reg_idx: REG_FOG_ENABLED, default: '0};
      s.is_reg    = 1'b1;
      s.reg_idx   = idx;
      s.reg_value = value;
      return s;
   endfunction

   function automatic step_type item_step(logic [1:0] mode, logic [31:0] wx, logic [31:0] wz,
                                          logic [7:0] px, logic [7:0] py, bit fixed,
                                          rsp_type answer);
      step_type s;
      s = '{reg_idx: REG_FOG_ENABLED, default: '0};
      s.item   = item_of(mode, wx, wz, px, py);
      s.fixed  = fixed;
      s.answer = answer;
      return s;
   endfunction

   // Append one row to the directed table.
   function automatic void add_step(step_type s);
      steps.insert(steps.size(), s);
   endfunction

   function automatic logic [31:0] pick_world(longint lo, int unsigned span);
      if (span == 0 || $urandom_range(99) < 15) return $urandom;
      return 32'(lo + longint'($urandom_range(span)));
   endfunction

   // Reads aim near the last reveal half of the time.
   function automatic logic [7:0] pick_pixel(longint center, int reach);
      longint v;
      if (center < 0 || center > GRID_SIZE - 1 || $urandom_range(1) == 0)
         return 8'($urandom_range(255));
      v = center - reach + longint'($urandom_range(2 * reach));
      if (v < 0) v = 0;
      if (v > GRID_SIZE - 1) v = GRID_SIZE - 1;
      return v[7:0];
   endfunction

   // Random items: mostly moves and reads, a few clears and unused modes.
   task automatic run_segment(int count, int move_pct, longint lo, int unsigned span);
      req_type it;
      longint  cx;
      longint  cy;
      int      pick;
      int      reach;
      cx = -1;
      cy = -1;
      repeat (count) begin
         it = item_of(MODE_READ, $urandom, $urandom, 8'($urandom_range(255)),
                      8'($urandom_range(255)));
         pick = $urandom_range(999);
         if (pick < 5) begin
            it.mode = MODE_CLEAR;
         end else if (pick < 45) begin
            it.mode = MODE_UNUSED;
         end else if (pick < 45 + move_pct * 10) begin
            it.mode    = MODE_MOVE;
            it.world_x = pick_world(lo, span);
            it.world_z = pick_world(lo, span);
            cx = map_to_cell(it.world_x, cfg_half, cfg_scale);
            cy = map_to_cell(it.world_z, cfg_half, cfg_scale);
         end else begin
            reach = int'(cfg_radius) + 2;
            it.pixel_x = pick_pixel(cx, reach);
            it.pixel_y = pick_pixel(cy, reach);
         end
         send_item(it, 1'b0, BLANK_PIXEL);
      end
   endtask

   // Main sequence: reset, directed table, then random segments.
   initial begin
      longint      lo;
      int unsigned span;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_data    <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;

      // Reset state: fog off, so every read shows the visible colour.
      add_step(item_step(MODE_READ, 32'd0, 32'd0, 8'd0, 8'd0, 1'b1, VISIBLE_HIDDEN));
      add_step(item_step(MODE_READ, 32'd0, 32'd0, 8'd255, 8'd255, 1'b1, VISIBLE_HIDDEN));
      add_step(item_step(MODE_MOVE, 32'd0, 32'd0, 8'd0, 8'd0, 1'b1, BLANK_PIXEL));
      add_step(item_step(MODE_UNUSED, '1, '1, 8'd255, 8'd255, 1'b1, BLANK_PIXEL));
      // Fog on with a white background; reset mapping puts world 0 at cell 1.
      add_step(reg_step(REG_FOG_ENABLED, 32'd1));
      add_step(reg_step(REG_BACKGROUND_COLOUR, 32'hFFFFFF));
      add_step(item_step(MODE_READ, 32'd0, 32'd0, 8'd10, 8'd10, 1'b1, WHITE_HIDDEN));
      add_step(item_step(MODE_MOVE, 32'd0, 32'd0, 8'd0, 8'd0, 1'b1, BLANK_PIXEL));
      add_step(item_step(MODE_READ, 32'd0, 32'd0, 8'd1, 8'd1, 1'b1, VISIBLE_SHOWN));
      add_step(item_step(MODE_READ, 32'd0, 32'd0, 8'd2, 8'd2, 1'b1, WHITE_HIDDEN));
      add_step(item_step(MODE_READ, 32'd0, 32'd0, 8'd0, 8'd1, 1'b1, VISIBLE_SHOWN));
      add_step(item_step(MODE_READ, 32'd0, 32'd0, 8'd1, 8'd0, 1'b0, BLANK_PIXEL));
      // Radius zero, world extremes map far outside the grid.
      add_step(reg_step(REG_REVEAL_RADIUS, 32'd0));
      add_step(item_step(MODE_MOVE, 32'h7FFFFFFF, 32'h80000000, 8'd0, 8'd0, 1'b1,
                         BLANK_PIXEL));
      // Identity mapping: only the center cell at radius zero.
      add_step(reg_step(REG_HALF_EXTENT, 32'd0));
      add_step(reg_step(REG_TEXEL_SCALE, 32'h00010000));
      add_step(item_step(MODE_MOVE, 32'h00648000, 32'h00640000, 8'd0, 8'd0, 1'b0,
                         BLANK_PIXEL));
      add_step(item_step(MODE_READ, 32'd0, 32'd0, 8'd100, 8'd100, 1'b0, BLANK_PIXEL));
      add_step(item_step(MODE_READ, 32'd0, 32'd0, 8'd101, 8'd100, 1'b0, BLANK_PIXEL));
      // Center left of the grid: a negative coordinate truncates toward zero.
      add_step(reg_step(REG_REVEAL_RADIUS, 32'd3));
      add_step(item_step(MODE_MOVE, 32'hFFFD8000, 32'h00FEC000, 8'd0, 8'd0, 1'b0,
                         BLANK_PIXEL));
      add_step(item_step(MODE_READ, 32'd0, 32'd0, 8'd0, 8'd254, 1'b0, BLANK_PIXEL));
      add_step(item_step(MODE_READ, 32'd0, 32'd0, 8'd0, 8'd255, 1'b0, BLANK_PIXEL));
      add_step(item_step(MODE_READ, 32'd0, 32'd0, 8'd1, 8'd251, 1'b0, BLANK_PIXEL));
      // Clear hides everything again.
      add_step(item_step(MODE_CLEAR, 32'd0, 32'd0, 8'd0, 8'd0, 1'b1, BLANK_PIXEL));
      add_step(item_step(MODE_READ, 32'd0, 32'd0, 8'd100, 8'd100, 1'b1, WHITE_HIDDEN));
      // Radius 256 around a center outside the grid.
      add_step(reg_step(REG_REVEAL_RADIUS, 32'd256));
      add_step(reg_step(REG_BACKGROUND_COLOUR, 32'd0));
      add_step(item_step(MODE_MOVE, 32'hFF9C0000, 32'h00800000, 8'd0, 8'd0, 1'b0,
                         BLANK_PIXEL));
      add_step(item_step(MODE_READ, 32'd0, 32'd0, 8'd0, 8'd0, 1'b0, BLANK_PIXEL));
      add_step(item_step(MODE_READ, 32'd0, 32'd0, 8'd255, 8'd0, 1'b0, BLANK_PIXEL));
      add_step(item_step(MODE_READ, 32'd0, 32'd0, 8'd255, 8'd255, 1'b0, BLANK_PIXEL));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (steps[i]) begin
         if (steps[i].is_reg) begin
            wait_idle();
            write_register(steps[i].reg_idx, steps[i].reg_value);
         end else begin
            send_item(steps[i].item, steps[i].fixed, steps[i].answer);
         end
      end

      // Random part, first with a slow receiver.
      set_extent_config(1'b1, 9'd3, lo, span);
      run_segment(110, 40, lo, span);
      set_config(1'b1, 24'd0, 31'h7FFFFFFF, 32'd300, 9'd0);
      run_segment(100, 45, 0, 0);

      // Slow sender.
      wait_idle();
      send_idle_pct = 54;
      recv_idle_pct = 9;
      set_config(1'b1, 24'hFFFFFF, 31'd0, 32'hFFFFFFFF, 9'($urandom_range(10, 4)));
      run_segment(110, 40, -20, 300);
      set_extent_config(1'b0, 9'd5, lo, span);
      run_segment(60, 40, lo, span);

      // No idling on either side.
      wait_idle();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_config(1'b1, 24'($urandom), 31'($urandom), 32'd0, 9'd2);
      run_segment(40, 40, 0, 0);
      set_extent_config(1'b1, 9'd256, lo, span);
      run_segment(10, 20, lo, span);
      set_extent_config(1'b1, 9'($urandom_range(6, 1)), lo, span);
      run_segment(170, 40, lo, span);

      // Drain and report.
      req_valid <= 1'b0;
      while (results_seen < items_sent) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_pixels.size() != 0) begin
         note_error($sformatf("%0d result items never arrived", expected_pixels.size()));
      end
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/fmdr_pkg.sv
rtl/fmdr_ram.sv
rtl/fmdr_mul.sv
rtl/fog_mask_disk_reveal.sv
tb/tb_fog_mask_disk_reveal.sv
